/* sv/assert_macros.svh */
// Assertion macros shared by the RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check that prop holds at every clock edge outside reset.
`define ASSERT_AT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that expr never holds at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_AT(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, expr, msg)
`endif

`endif

/* sv/fukq_pkg.sv */
// Shared types and constants of the unique-key queue.
// Used by the top level fifo_unique_key_queue.
package fukq_pkg;

   localparam int DEPTH     = 16;
   localparam int KEY_BITS  = 16;
   localparam int DATA_BITS = 32;

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int OCC_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = KEY_BITS + DATA_BITS;

   localparam int KEY_W  = 16;
   localparam int DATA_W = 32;
   localparam int OP_W   = 2;
   localparam int ST_W   = 2;
   localparam int OCC_OUT_W = 5;

   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_POP  = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_DUP   = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [KEY_W-1:0]         in_key;
      logic signed [DATA_W-1:0] in_data;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0]         out_key;
      logic signed [DATA_W-1:0] out_data;
      logic [ST_W-1:0]          status;
      logic                     is_empty;
      logic [OCC_OUT_W-1:0]     occupancy;
   } rsp_type;

endpackage

/* sv/fifo_unique_key_queue.sv */
// Top level of the unique-key queue: sequencer, ring pointers, result register.
// Depends on fukq_pkg, fukq_ram and assert_macros.svh.
`include "assert_macros.svh"

// A FIFO of (key, data) entries in a ring of DEPTH slots that refuses a push
// whose key is already held. One request is worked on at a time: a push walks
// the held keys one per cycle through the single read port of the entry RAM
// in SCAN, stopping early when a duplicate key is found, and then goes to
// RESP; pop and peek go through READ, FETCH and RESP, while an empty pop or
// peek and the unused op code go straight to RESP. The result sits in an
// output register, so a new request is accepted while the previous result
// still waits on rsp_ready; the response step then holds until that register
// frees up.
// No clearing pass is needed after reset.
module fifo_unique_key_queue
   import fukq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      READ,
      FETCH,
      RESP
   } state_type;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [OCC_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [OCC_W-1:0]      scan_left_ff, scan_left_in;
   logic                  pend_ff, pend_in;
   req_type               req_ff, req_in;
   logic [KEY_BITS-1:0]   res_key_ff, res_key_in;
   logic [DATA_BITS-1:0]  res_data_ff, res_data_in;
   logic [ST_W-1:0]       res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  ram_wr_en;
   logic [WORD_W-1:0]     ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [WORD_W-1:0]     ram_rd_data;
   logic [KEY_BITS-1:0]   req_key;
   logic [KEY_BITS-1:0]   rd_key;
   logic [DATA_BITS-1:0]  rd_dat;

   assign req_key     = KEY_BITS'(req_ff.in_key);
   assign rd_key      = ram_rd_data[WORD_W-1 -: KEY_BITS];
   assign rd_dat      = ram_rd_data[DATA_BITS-1:0];
   assign ram_wr_data = {req_key, DATA_BITS'($unsigned(req_ff.in_data))};

   fukq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      scan_left_in  = scan_left_ff;
      pend_in       = pend_ff;
      req_in        = req_ff;
      res_key_in    = res_key_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_in        = rsp_ff;
      req_ready     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = scan_idx_ff;

      unique case (state_ff)
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in        = req_data;
               res_key_in    = '0;
               res_data_in   = '0;
               res_status_in = ST_OK;
               if (req_data.op == OP_PUSH) begin
                  scan_idx_in  = head_ff;
                  scan_left_in = count_ff;
                  pend_in      = 1'b0;
                  state_in     = SCAN;
               end else if (req_data.op == OP_POP || req_data.op == OP_PEEK) begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = RESP;
                  end else begin
                     state_in = READ;
                  end
               end else begin
                  state_in = RESP;
               end
            end
         end
         SCAN: begin
            // issue the next held slot while comparing the one read last cycle
            ram_rd_en = (scan_left_ff != '0);
            if (scan_left_ff != '0) begin
               scan_idx_in  = ring_next(scan_idx_ff);
               scan_left_in = scan_left_ff - 1'b1;
            end
            pend_in = (scan_left_ff != '0);
            if (pend_ff && rd_key == req_key) begin
               res_status_in = ST_DUP;
               state_in      = RESP;
            end else if (scan_left_ff == '0) begin
               if (count_ff == OCC_W'(DEPTH)) begin
                  res_status_in = ST_FULL;
               end else begin
                  ram_wr_en = 1'b1;
                  tail_in   = ring_next(tail_ff);
                  count_in  = count_ff + 1'b1;
               end
               state_in = RESP;
            end
         end
         READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = head_ff;
            state_in    = FETCH;
         end
         FETCH: begin
            res_key_in  = rd_key;
            res_data_in = rd_dat;
            if (req_ff.op == OP_POP) begin
               head_in  = ring_next(head_ff);
               count_in = count_ff - 1'b1;
            end
            state_in = RESP;
         end
         RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.out_key   = KEY_W'(res_key_ff);
               rsp_in.out_data  = DATA_W'(res_data_ff);
               rsp_in.status    = res_status_ff;
               rsp_in.is_empty  = (count_ff == '0);
               rsp_in.occupancy = OCC_OUT_W'(count_ff);
               rsp_valid_in     = 1'b1;
               state_in         = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      scan_left_ff  <= scan_left_in;
      pend_ff       <= pend_in;
      req_ff        <= req_in;
      res_key_ff    <= res_key_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
      if (reset) begin
         state_ff     <= IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > OCC_W'(DEPTH), "occupancy above depth")
   `ASSERT_AT(a_ring_align, clock, reset, (count_ff == '0 || count_ff == OCC_W'(DEPTH)) |-> head_ff == tail_ff, "head and tail disagree with occupancy")
   `ASSERT_AT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "request accepted while busy")
   `ASSERT_AT(a_rsp_from_seq, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == RESP), "result loaded outside response step")

endmodule

/* sv/fukq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module fukq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
